[rtl/dcfs_pkg.sv]
// ----------------------------------------------------------------------------
// dcfs_pkg
// Types and constants shared by the dual camera frame selector modules.
// ----------------------------------------------------------------------------
package dcfs_pkg;

    localparam int TIME_W      = 32;
    localparam int THRESH_W    = 16;
    localparam int TIMEOUT_W   = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LATE_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPLAY_TIMEOUT = 1'd1;

    // reset values of the configuration registers
    localparam logic [THRESH_W-1:0]  LATE_THRESHOLD_RST = 16'd100;
    localparam logic [TIMEOUT_W-1:0] REPLAY_TIMEOUT_RST = 4'd11;

    typedef struct packed {
        logic [TIME_W-1:0] upper_time;
        logic [TIME_W-1:0] lower_time;
        logic              replay_active;
        logic              log_data_ready;
    } poll_t;

    typedef struct packed {
        logic process_frame;
        logic select_upper;
        logic ack_log_frame;
        logic wait_next;
    } result_t;

    typedef struct packed {
        logic [THRESH_W-1:0]  late_threshold;
        logic [TIMEOUT_W-1:0] replay_timeout;
    } cfg_t;

endpackage

[rtl/dcfs_if.sv]
// ----------------------------------------------------------------------------
// dcfs channel interfaces
// Poll request, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface dcfs_poll_if;
    logic                           valid;
    logic                           ready;
    logic [dcfs_pkg::TIME_W-1:0]    upper_time;
    logic [dcfs_pkg::TIME_W-1:0]    lower_time;
    logic                           replay_active;
    logic                           log_data_ready;

    modport source (output valid, upper_time, lower_time, replay_active,
                    log_data_ready, input ready);
    modport sink   (input valid, upper_time, lower_time, replay_active,
                    log_data_ready, output ready);
endinterface

interface dcfs_result_if;
    logic valid;
    logic ready;
    logic process_frame;
    logic select_upper;
    logic ack_log_frame;
    logic wait_next;

    modport source (output valid, process_frame, select_upper, ack_log_frame,
                    wait_next, input ready);
    modport sink   (input valid, process_frame, select_upper, ack_log_frame,
                    wait_next, output ready);
endinterface

interface dcfs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dcfs_pkg::CFG_IDX_W-1:0]    index;
    logic [dcfs_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/dcfs_cfg_regs.sv]
// ----------------------------------------------------------------------------
// dcfs_cfg_regs
// Configuration registers: late threshold and replay timeout.
// ----------------------------------------------------------------------------
module dcfs_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    dcfs_cfg_if.sink          cfg,
    output dcfs_pkg::cfg_t    cfg_val
);

    logic [dcfs_pkg::THRESH_W-1:0]  late_threshold_reg;
    logic [dcfs_pkg::TIMEOUT_W-1:0] replay_timeout_reg;
    logic                           wr_en;

    // writes are always taken
    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            late_threshold_reg <= dcfs_pkg::LATE_THRESHOLD_RST;
            replay_timeout_reg <= dcfs_pkg::REPLAY_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            case (cfg.index)
                dcfs_pkg::REG_LATE_THRESHOLD:
                    late_threshold_reg <= cfg.data[dcfs_pkg::THRESH_W-1:0];
                dcfs_pkg::REG_REPLAY_TIMEOUT:
                    replay_timeout_reg <= cfg.data[dcfs_pkg::TIMEOUT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_val.late_threshold = late_threshold_reg;
    assign cfg_val.replay_timeout = replay_timeout_reg;

endmodule

[rtl/dcfs_decide.sv]
// ----------------------------------------------------------------------------
// dcfs_decide
// Selector state and the per-poll decision logic; state moves on advance.
// ----------------------------------------------------------------------------
module dcfs_decide (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  dcfs_pkg::poll_t   poll,
    input  dcfs_pkg::cfg_t    cfg_val,
    output dcfs_pkg::result_t result
);

    logic                            accept_pending_reg, accept_pending_next;
    logic                            upper_fresh_reg, upper_fresh_next;
    logic                            lower_fresh_reg, lower_fresh_next;
    logic [dcfs_pkg::TIME_W-1:0]     prev_upper_time_reg, prev_upper_time_next;
    logic [dcfs_pkg::TIME_W-1:0]     prev_lower_time_reg, prev_lower_time_next;
    logic [dcfs_pkg::TIME_W-1:0]     accepted_time_reg, accepted_time_next;
    logic                            current_upper_reg, current_upper_next;
    logic [dcfs_pkg::TIMEOUT_W-1:0]  delay_count_reg, delay_count_next;

    logic [dcfs_pkg::TIME_W-1:0]     diff_ul;
    logic [dcfs_pkg::TIME_W-1:0]     diff_lu;
    logic [dcfs_pkg::TIME_W-1:0]     thresh_ext;
    logic                            upper_late;
    logic                            lower_late;
    logic                            upper_new;
    logic                            lower_new;
    logic                            empty_poll;
    logic                            take;
    logic [dcfs_pkg::TIMEOUT_W-1:0]  delay_inc;
    logic                            process_frame;
    logic                            ack_log_frame;

    // lateness on the wrapping difference read as signed
    assign thresh_ext = {{(dcfs_pkg::TIME_W-dcfs_pkg::THRESH_W){1'b0}},
                         cfg_val.late_threshold};
    assign diff_ul    = poll.lower_time - poll.upper_time;
    assign diff_lu    = poll.upper_time - poll.lower_time;
    assign upper_late = !diff_ul[dcfs_pkg::TIME_W-1] && (diff_ul >= thresh_ext);
    assign lower_late = !diff_lu[dcfs_pkg::TIME_W-1] && (diff_lu >= thresh_ext);

    // freshness against last seen and last accepted timestamps
    assign upper_new = (poll.upper_time != prev_upper_time_reg) &&
                       (poll.upper_time >= accepted_time_reg);
    assign lower_new = (poll.lower_time != prev_lower_time_reg) &&
                       (poll.lower_time >= accepted_time_reg);

    assign empty_poll = poll.replay_active && !poll.log_data_ready &&
                        (delay_count_reg == '0);
    assign delay_inc  = delay_count_reg + 1'b1;

    // next state and result of one poll
    always_comb
    begin
        logic uf;
        logic lf;
        logic cur;
        uf  = upper_fresh_reg | upper_new;
        lf  = lower_fresh_reg | lower_new;
        cur = current_upper_reg;

        accept_pending_next  = accept_pending_reg;
        upper_fresh_next     = upper_fresh_reg;
        lower_fresh_next     = lower_fresh_reg;
        prev_upper_time_next = prev_upper_time_reg;
        prev_lower_time_next = prev_lower_time_reg;
        accepted_time_next   = accepted_time_reg;
        current_upper_next   = current_upper_reg;
        delay_count_next     = delay_count_reg;
        process_frame        = 1'b0;
        ack_log_frame        = 1'b0;
        take                 = 1'b0;

        if (empty_poll)
        begin
            accept_pending_next = 1'b0;
        end
        else
        begin
            prev_upper_time_next = poll.upper_time;
            prev_lower_time_next = poll.lower_time;
            upper_fresh_next     = uf;
            lower_fresh_next     = lf;
            take = accept_pending_reg || (uf && lf) || (uf && lower_late) ||
                   (lf && upper_late);
            if (take)
            begin
                delay_count_next = '0;
                ack_log_frame    = poll.replay_active;
                process_frame    = 1'b1;
                if (upper_late)
                    cur = 1'b0;
                else if (lower_late)
                    cur = 1'b1;
                else
                    cur = !current_upper_reg;
                current_upper_next = cur;
                if (cur)
                begin
                    accepted_time_next  = poll.upper_time;
                    upper_fresh_next    = 1'b0;
                    lower_fresh_next    = lf && (poll.upper_time <= poll.lower_time);
                    accept_pending_next = lf && (poll.upper_time <= poll.lower_time);
                end
                else
                begin
                    accepted_time_next  = poll.lower_time;
                    lower_fresh_next    = 1'b0;
                    upper_fresh_next    = uf && (poll.lower_time <= poll.upper_time);
                    accept_pending_next = uf && (poll.lower_time <= poll.upper_time);
                end
            end
            else if (poll.replay_active)
            begin
                delay_count_next = delay_inc;
                if (delay_inc >= cfg_val.replay_timeout)
                begin
                    ack_log_frame      = 1'b1;
                    delay_count_next   = {{(dcfs_pkg::TIMEOUT_W-1){1'b0}}, 1'b1};
                    accepted_time_next = '0;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_pending_reg  <= 1'b0;
            upper_fresh_reg     <= 1'b0;
            lower_fresh_reg     <= 1'b0;
            prev_upper_time_reg <= '0;
            prev_lower_time_reg <= '0;
            accepted_time_reg   <= '0;
            current_upper_reg   <= 1'b0;
            delay_count_reg     <= '0;
        end
        else if (advance)
        begin
            accept_pending_reg  <= accept_pending_next;
            upper_fresh_reg     <= upper_fresh_next;
            lower_fresh_reg     <= lower_fresh_next;
            prev_upper_time_reg <= prev_upper_time_next;
            prev_lower_time_reg <= prev_lower_time_next;
            accepted_time_reg   <= accepted_time_next;
            current_upper_reg   <= current_upper_next;
            delay_count_reg     <= delay_count_next;
        end
    end

    assign result.process_frame = process_frame;
    assign result.select_upper  = process_frame && current_upper_next;
    assign result.ack_log_frame = ack_log_frame;
    assign result.wait_next     = !accept_pending_next && (delay_count_next == '0);

endmodule

[rtl/dual_camera_frame_selector.sv]
// ----------------------------------------------------------------------------
// dual_camera_frame_selector
// Chooses which of two camera sources delivers the next frame to process.
// ----------------------------------------------------------------------------
// One poll request gives exactly one result. A request is registered on
// acceptance, then decided against the selector state and written to the
// result register once that register is free or draining; a new request is
// taken every cycle while the result side does not stall. The only limit
// on rate is the result register: when the result side stalls, the request
// register fills and ready drops after one more request. Configuration
// writes are always ready and take effect on the next poll decided.
module dual_camera_frame_selector (
    input  logic           clk,
    input  logic           rst_n,
    dcfs_poll_if.sink      poll,
    dcfs_result_if.source  result,
    dcfs_cfg_if.sink       cfg
);

    dcfs_pkg::cfg_t      cfg_val;
    dcfs_pkg::poll_t     poll_reg;
    dcfs_pkg::result_t   decided;
    dcfs_pkg::result_t   result_reg;
    logic                poll_valid_reg;
    logic                result_valid_reg;
    logic                advance;
    logic                poll_take;

    dcfs_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    // a registered request moves on when the result slot is free or draining
    assign advance   = poll_valid_reg && (!result_valid_reg || result.ready);
    assign poll.ready = !poll_valid_reg || advance;
    assign poll_take = poll.valid && poll.ready;

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            poll_valid_reg <= 1'b0;
        else if (poll.ready)
            poll_valid_reg <= poll.valid;
    end

    always_ff @(posedge clk)
    begin
        if (poll_take)
        begin
            poll_reg.upper_time     <= poll.upper_time;
            poll_reg.lower_time     <= poll.lower_time;
            poll_reg.replay_active  <= poll.replay_active;
            poll_reg.log_data_ready <= poll.log_data_ready;
        end
    end

    dcfs_decide u_decide (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .poll    (poll_reg),
        .cfg_val (cfg_val),
        .result  (decided)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (result.ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= decided;
    end

    assign result.valid         = result_valid_reg;
    assign result.process_frame = result_reg.process_frame;
    assign result.select_upper  = result_reg.select_upper;
    assign result.ack_log_frame = result_reg.ack_log_frame;
    assign result.wait_next     = result_reg.wait_next;

endmodule
